>>> rtl/mds_pkg.sv
package mds_pkg;

  localparam int SEED_W     = 24;
  localparam int NEXT_W     = 27;
  localparam int SQ_W       = 48;
  localparam int MAX_DIGITS = 7;
  localparam int DIGITS     = 14;
  localparam int WIN_DIGITS = 8;
  localparam int HALF_W     = 14;
  localparam int DAB_STEPS  = 8;
  localparam int DAB_STAGES = SQ_W / DAB_STEPS;

  localparam logic [SEED_W-1:0] SEED_MAX = 24'd9999999;
  localparam logic [HALF_W-1:0] HALF_SCALE = 14'd10000;

  localparam logic [SEED_W-1:0] POW10_SEED [MAX_DIGITS] = '{
    24'd1, 24'd10, 24'd100, 24'd1000, 24'd10000, 24'd100000, 24'd1000000
  };

  typedef logic [DIGITS-1:0][3:0]     bcd_t;
  typedef logic [WIN_DIGITS-1:0][3:0] win_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] n;
  } mds_ctl_t;

endpackage

>>> rtl/middle_square_decimal_step.sv
// channel   ports                         transfer when
// input     start, busy, in_seed[23:0]    start && !busy
// result    out_valid, out_next_value     out_valid (one cycle strobe)
//
// One seed per cycle; busy stays low. The pipe stages from the start
// transfer to out_valid are: saturate, square, six binary-to-BCD stages
// of eight shift steps each, two window stages, two BCD-to-binary stages.
// rst_n (synchronous) clears only the valid bits along the pipe.
// The receiver cannot stall, so nothing ever holds back the pipe.
module middle_square_decimal_step import mds_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SEED_W-1:0] in_seed,
  output logic              busy,
  output logic              out_valid,
  output logic [NEXT_W-1:0] out_next_value
);

  mds_ctl_t        ctl_s [DAB_STAGES+1];
  logic [SQ_W-1:0] bin_s [DAB_STAGES+1];
  bcd_t            bcd_s [DAB_STAGES+1];
  logic            win_valid;
  win_t            win;

  assign busy     = 1'b0;
  assign bcd_s[0] = '0;

  mds_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .seed     (in_seed),
    .ctl_o    (ctl_s[0]),
    .sq_o     (bin_s[0])
  );

  for (genvar g = 0; g < DAB_STAGES; g++) begin : g_dab
    mds_bcd_stage u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl_s[g]),
      .bin_i (bin_s[g]),
      .bcd_i (bcd_s[g]),
      .ctl_o (ctl_s[g+1]),
      .bin_o (bin_s[g+1]),
      .bcd_o (bcd_s[g+1])
    );
  end

  mds_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (ctl_s[DAB_STAGES]),
    .bcd_i   (bcd_s[DAB_STAGES]),
    .valid_o (win_valid),
    .win_o   (win)
  );

  mds_to_bin u_to_bin (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (win_valid),
    .win_i   (win),
    .valid_o (out_valid),
    .value_o (out_next_value)
  );

  a_xfer_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##12 out_valid)
    else $error("transfer did not produce a result");

  a_result_from_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 12))
    else $error("result without a matching transfer");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_next_value <= 27'd99999999))
    else $error("result exceeds eight decimal digits");

endmodule

>>> rtl/mds_front.sv
module mds_front import mds_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [SEED_W-1:0] seed,
  output mds_ctl_t          ctl_o,
  output logic [SQ_W-1:0]   sq_o
);

  logic              valid_a_r;
  logic [SEED_W-1:0] x_a_r;
  logic [SEED_W-1:0] x_nxt;
  mds_ctl_t          ctl_b_r;
  logic [2:0]        n_nxt;
  logic [SQ_W-1:0]   sq_b_r;
  logic [SQ_W-1:0]   sq_nxt;

  always_comb begin
    x_nxt = (seed > SEED_MAX) ? SEED_MAX : seed;
  end

  // digit count of the seed, zero counts as one digit
  always_comb begin
    n_nxt = 3'd1;
    for (int i = 1; i < MAX_DIGITS; i++) begin
      if (x_a_r >= POW10_SEED[i]) n_nxt = n_nxt + 3'd1;
    end
    sq_nxt = SQ_W'(x_a_r) * SQ_W'(x_a_r);
  end

  always_ff @(posedge clk) begin
    x_a_r     <= x_nxt;
    ctl_b_r.n <= n_nxt;
    sq_b_r    <= sq_nxt;
    if (!rst_n) begin
      valid_a_r     <= 1'b0;
      ctl_b_r.valid <= 1'b0;
    end else begin
      valid_a_r     <= in_valid;
      ctl_b_r.valid <= valid_a_r;
    end
  end

  assign ctl_o = ctl_b_r;
  assign sq_o  = sq_b_r;

endmodule

>>> rtl/mds_bcd_stage.sv
module mds_bcd_stage import mds_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  mds_ctl_t        ctl_i,
  input  logic [SQ_W-1:0] bin_i,
  input  bcd_t            bcd_i,
  output mds_ctl_t        ctl_o,
  output logic [SQ_W-1:0] bin_o,
  output bcd_t            bcd_o
);

  mds_ctl_t        ctl_r;
  logic [SQ_W-1:0] bin_r;
  logic [SQ_W-1:0] bin_nxt;
  bcd_t            bcd_r;
  bcd_t            bcd_nxt;

  // shift-and-add-3, one binary bit per step
  always_comb begin
    bcd_nxt = bcd_i;
    bin_nxt = bin_i;
    for (int s = 0; s < DAB_STEPS; s++) begin
      for (int j = 0; j < DIGITS; j++) begin
        if (bcd_nxt[j] >= 4'd5) bcd_nxt[j] = bcd_nxt[j] + 4'd3;
      end
      {bcd_nxt, bin_nxt} = {bcd_nxt, bin_nxt} << 1;
    end
  end

  always_ff @(posedge clk) begin
    ctl_r.n <= ctl_i.n;
    bin_r   <= bin_nxt;
    bcd_r   <= bcd_nxt;
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_i.valid;
    end
  end

  assign ctl_o = ctl_r;
  assign bin_o = bin_r;
  assign bcd_o = bcd_r;

endmodule

>>> rtl/mds_window.sv
module mds_window import mds_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mds_ctl_t ctl_i,
  input  bcd_t     bcd_i,
  output logic     valid_o,
  output win_t     win_o
);

  mds_ctl_t   ctl_r;
  bcd_t       bcd_r;
  logic [3:0] d_r;
  logic [3:0] d_nxt;
  logic [3:0] len;
  logic [3:0] n4;
  logic [3:0] k;
  logic [3:0] top;
  logic       short_win;
  logic [3:0] p;
  logic [3:0] w;
  logic [3:0] idx;
  logic       valid_r;
  win_t       win_r;
  win_t       win_nxt;

  // digit count of the square, then d = L - n
  always_comb begin
    len = 4'd1;
    for (int j = 0; j < DIGITS; j++) begin
      if (bcd_i[j] != 4'd0) len = 4'(j + 1);
    end
    d_nxt = (len >= {1'b0, ctl_i.n}) ? len - {1'b0, ctl_i.n} : 4'd0;
  end

  // first window starts at floor(d/2); it is short when n > 1 and its top digit is zero
  always_comb begin
    n4        = {1'b0, ctl_r.n};
    k         = {1'b0, d_r[3:1]};
    top       = k + n4 - 4'd1;
    short_win = (ctl_r.n != 3'd1) && (bcd_r[top] == 4'd0);
    p         = k;
    w         = n4;
    if (short_win) begin
      if (d_r[0]) begin
        p = k + 4'd1;
      end else begin
        p = (d_r >= 4'd2) ? k - 4'd1 : 4'd0;
        w = n4 + 4'd1;
      end
    end
    for (int i = 0; i < WIN_DIGITS; i++) begin
      idx        = p + 4'(i);
      win_nxt[i] = (4'(i) < w) ? bcd_r[idx] : 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    ctl_r.n <= ctl_i.n;
    bcd_r   <= bcd_i;
    d_r     <= d_nxt;
    win_r   <= win_nxt;
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
      valid_r     <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_i.valid;
      valid_r     <= ctl_r.valid;
    end
  end

  assign valid_o = valid_r;
  assign win_o   = win_r;

endmodule

>>> rtl/mds_to_bin.sv
module mds_to_bin import mds_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  input  win_t              win_i,
  output logic              valid_o,
  output logic [NEXT_W-1:0] value_o
);

  logic              valid_h_r;
  logic [HALF_W-1:0] lo_r;
  logic [HALF_W-1:0] hi_r;
  logic [HALF_W-1:0] lo_nxt;
  logic [HALF_W-1:0] hi_nxt;
  logic              valid_r;
  logic [NEXT_W-1:0] value_r;
  logic [NEXT_W-1:0] value_nxt;

  // two four-digit halves, then hi * 10^4 + lo
  always_comb begin
    lo_nxt = HALF_W'(win_i[0]) + HALF_W'(win_i[1]) * 14'd10
           + HALF_W'(win_i[2]) * 14'd100 + HALF_W'(win_i[3]) * 14'd1000;
    hi_nxt = HALF_W'(win_i[4]) + HALF_W'(win_i[5]) * 14'd10
           + HALF_W'(win_i[6]) * 14'd100 + HALF_W'(win_i[7]) * 14'd1000;
    value_nxt = NEXT_W'(hi_r) * NEXT_W'(HALF_SCALE) + NEXT_W'(lo_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_h_r <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      valid_h_r <= valid_i;
      valid_r   <= valid_h_r;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    value_r <= value_nxt;
  end

  assign valid_o = valid_r;
  assign value_o = value_r;

endmodule

>>> bench/tb_middle_square_decimal_step.sv
module tb_middle_square_decimal_step import mds_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_DEPTH   = 12;
  localparam int RANDOM_SEEDS = 450;
  localparam int CYCLE_LIMIT  = 50000;

  class next_value_board;
    logic [NEXT_W-1:0] next_values_due[$];
    int unsigned       mismatches = 0;

    static function automatic longint unsigned ten_pow(int unsigned k);
      longint unsigned p;
      p = 1;
      repeat (k) p = p * 10;
      return p;
    endfunction

    static function automatic int unsigned dec_len(longint unsigned v);
      int unsigned c;
      c = 1;
      while (c < 16 && v >= ten_pow(c)) c++;
      return c;
    endfunction

    // n-digit window from the middle of the square, with the fallback window
    // when the first one comes out short
    static function automatic logic [NEXT_W-1:0] middle_digits(logic [SEED_W-1:0] seed);
      longint unsigned x, sq, win;
      int unsigned     n, len, d, sh;
      x = seed;
      if (x > SEED_MAX) x = SEED_MAX;
      sq  = x * x;
      n   = dec_len(x);
      len = dec_len(sq);
      d   = (len >= n) ? len - n : 0;
      if (d % 2 == 1) win = (sq / ten_pow((d - 1) / 2)) % ten_pow(n);
      else win = (sq / ten_pow(d / 2)) % ten_pow(n);
      if (dec_len(win) < n) begin
        if (d % 2 == 1) begin
          win = (sq / ten_pow((d + 1) / 2)) % ten_pow(n);
        end else begin
          sh  = (d >= 2) ? d / 2 - 1 : 0;
          win = (sq / ten_pow(sh)) % ten_pow(n + 1);
        end
      end
      return win[NEXT_W-1:0];
    endfunction

    function void note_seed(logic [SEED_W-1:0] seed);
      next_values_due = {next_values_due, middle_digits(seed)};
    endfunction

    function void check_next_value(logic [NEXT_W-1:0] actual);
      logic [NEXT_W-1:0] want;
      if (next_values_due.size() == 0) begin
        $error("out_next_value: expected none, actual %0d", actual);
        mismatches++;
      end else begin
        want = next_values_due.pop_front();
        if (want !== actual) begin
          $error("out_next_value: expected %0d, actual %0d", want, actual);
          mismatches++;
        end
      end
    endfunction

    function int unsigned outstanding();
      return next_values_due.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic [SEED_W-1:0] in_seed;
  logic              busy;
  logic              out_valid;
  logic [NEXT_W-1:0] out_next_value;

  next_value_board board = new();
  int unsigned     cycles = 0;

  middle_square_decimal_step DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_seed       (in_seed),
    .busy          (busy),
    .out_valid     (out_valid),
    .out_next_value(out_next_value)
  );

  always #5 clk = ~clk;

  // both channels observed at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) board.note_seed(in_seed);
      if (out_valid) board.check_next_value(out_next_value);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_middle_square_decimal_step failed");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_seed(input logic [SEED_W-1:0] seed);
    start   <= 1'b1;
    in_seed <= seed;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_for(input int unsigned gap);
    start   <= 1'b0;
    in_seed <= SEED_W'($urandom);
    repeat (gap) @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (board.outstanding() != 0);
  endtask

  function automatic logic [SEED_W-1:0] pick_seed();
    int unsigned     len, k;
    longint unsigned lo, hi;
    case ($urandom_range(0, 9))
      0: return SEED_W'($urandom);
      1: return SEED_W'($urandom_range(16777215, 10000000));
      2, 3: begin
        // mostly zeros: pushes the first window short
        k = $urandom_range(0, 5);
        return SEED_W'($urandom_range(99, 1) * next_value_board::ten_pow(k));
      end
      default: begin
        len = $urandom_range(1, MAX_DIGITS);
        lo  = (len == 1) ? 0 : next_value_board::ten_pow(len - 1);
        hi  = next_value_board::ten_pow(len) - 1;
        return SEED_W'($urandom_range(int'(hi), int'(lo)));
      end
    endcase
  endfunction

  logic [SEED_W-1:0] corner_seeds[] = '{
    24'd0, 24'd1, 24'd2, 24'd3, 24'd4, 24'd9, 24'd10, 24'd32, 24'd99, 24'd100,
    24'd1000, 24'd3162, 24'd9999, 24'd10000, 24'd31623, 24'd100000, 24'd999999,
    24'd1000000, 24'd3162278, 24'd9999999, 24'd10000000, 24'd16777215,
    24'h555555, 24'haaaaaa
  };

  initial begin
    int unsigned sent, burst;
    bit          paused;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_seed = '0;
    sent    = 0;
    paused  = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (corner_seeds[i]) begin
      send_seed(corner_seeds[i]);
      if ($urandom_range(0, 3) == 0) idle_for($urandom_range(1, 3));
    end
    drain();

    while (sent < RANDOM_SEEDS) begin
      // occasional long bursts run back to back with no gaps
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      if (burst > RANDOM_SEEDS - sent) burst = RANDOM_SEEDS - sent;
      repeat (burst) begin
        send_seed(pick_seed());
        sent++;
      end
      idle_for($urandom_range(1, 7));
      if (!paused && sent >= RANDOM_SEEDS / 2) begin
        drain();
        paused = 1'b1;
      end
    end

    drain();
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("tb_middle_square_decimal_step passed");
    end else begin
      $display("tb_middle_square_decimal_step failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/mds_pkg.sv
rtl/mds_front.sv
rtl/mds_bcd_stage.sv
rtl/mds_window.sv
rtl/mds_to_bin.sv
rtl/middle_square_decimal_step.sv
bench/tb_middle_square_decimal_step.sv
